// ----- rtl/fqa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the FIFO queue with average.
package fqa_pkg;

  localparam int DEPTH      = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VALUE_W    = 32;
  localparam int SUM_W      = VALUE_W + $clog2(DEPTH);
  localparam int FRAC_W     = 8;
  localparam int AVG_W      = 40;
  localparam int OCC_W      = 6;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int DIVD_W     = SUM_W + FRAC_W;
  localparam int STEP_W     = $clog2(DIVD_W);
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [CNT_W-1:0]      FILL_MAX   = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0]      PTR_LAST   = PTR_W'(DEPTH - 1);
  localparam logic [STEP_W-1:0]     STEP_LAST  = STEP_W'(DIVD_W - 1);
  localparam logic [CMDQ_CNT_W-1:0] CMDQ_FULL  = CMDQ_CNT_W'(CMDQ_DEPTH);

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_AVG  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic [VALUE_W-1:0] POPPED_EMPTY = '1;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_AVG,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped;
    logic signed [AVG_W-1:0]   average;
    logic [OCC_W-1:0]          occupancy;
  } out_item_t;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  function automatic op_e classify(input logic [REQ_W-1:0] req);
    op_e op;
    unique case (req)
      REQ_PUSH: op = OP_PUSH;
      REQ_POP:  op = OP_POP;
      REQ_AVG:  op = OP_AVG;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

  function automatic logic [SUM_W-1:0] ext_value(input logic [VALUE_W-1:0] v);
    return {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] f);
    return OCC_W'(f);
  endfunction

endpackage

// ----- rtl/fifo_queue_with_average_top.sv -----
`timescale 1ns / 1ps
// Top level of the FIFO queue of signed values with an average query.
// Push, spare code and empty pop or average results: command queue, then result register.
// A pop with data also waits in S_POP for the RAM read before its result is registered.
// An average query waits in S_DIV for the 45-step divider, one quotient bit per cycle.
// One transaction is executed at a time; the next starts only after the previous result is popped.
// Reset is synchronous and active low; it empties the queue and clears the sum and count.
module fifo_queue_with_average_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  fqa_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output fqa_pkg::out_item_t out_data
);

  logic          cmd_valid;
  logic          cmd_take;
  fqa_pkg::cmd_t cmd;
  logic          out_valid;

  fqa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  fqa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_take  (pop)
  );

  assign empty = !out_valid;

endmodule

// ----- rtl/fqa_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fqa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/fqa_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider that produces one quotient bit per cycle.
module fqa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  fqa_pkg::div_req_t         req,
  output logic                      done,
  output logic [fqa_pkg::DIVD_W-1:0] quotient
);

  logic                        busy_r;
  logic                        done_r;
  logic [fqa_pkg::STEP_W-1:0]  cnt_r;
  logic [fqa_pkg::CNT_W-1:0]   rem_r;
  logic [fqa_pkg::CNT_W-1:0]   rem_nxt;
  logic [fqa_pkg::DIVD_W-1:0]  quo_r;
  logic [fqa_pkg::DIVD_W-1:0]  quo_nxt;
  logic [fqa_pkg::CNT_W-1:0]   dsr_r;
  logic [fqa_pkg::CNT_W:0]     trial;
  logic [fqa_pkg::CNT_W:0]     diff;
  logic                        fits;

  always_comb begin
    trial   = {rem_r, quo_r[fqa_pkg::DIVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? diff[fqa_pkg::CNT_W-1:0] : trial[fqa_pkg::CNT_W-1:0];
    quo_nxt = {quo_r[fqa_pkg::DIVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= fqa_pkg::STEP_LAST;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/fqa_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and buffers them in a short command queue.
module fqa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  fqa_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output fqa_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  fqa_pkg::cmd_t                    slots_r [fqa_pkg::CMDQ_DEPTH];
  logic [fqa_pkg::CMDQ_PTR_W-1:0]   wr_ptr_r;
  logic [fqa_pkg::CMDQ_PTR_W-1:0]   rd_ptr_r;
  logic [fqa_pkg::CMDQ_CNT_W-1:0]   count_r;
  logic                             wr_fire;
  logic                             rd_fire;

  assign full      = count_r == fqa_pkg::CMDQ_FULL;
  assign cmd_valid = count_r != '0;
  assign cmd       = slots_r[rd_ptr_r];
  assign wr_fire   = push && !full;
  assign rd_fire   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      slots_r[wr_ptr_r] <= '{op: fqa_pkg::classify(in_data.req_type), value: in_data.value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count_r <= count_r + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_cmdq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fqa_pkg::CMDQ_FULL)
    else $error("Command queue count exceeds its depth.");
`endif

endmodule

// ----- rtl/fqa_back.sv -----
`timescale 1ns / 1ps
// Back end: holds the value store, running sum and fill count, and executes commands.
module fqa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  fqa_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_valid,
  output fqa_pkg::out_item_t out_item,
  input  logic               out_take
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DIV
  } state_e;

  state_e                       state_r;
  state_e                       state_nxt;
  logic [fqa_pkg::PTR_W-1:0]    head_r;
  logic [fqa_pkg::PTR_W-1:0]    head_nxt;
  logic [fqa_pkg::PTR_W-1:0]    tail_r;
  logic [fqa_pkg::PTR_W-1:0]    tail_nxt;
  logic [fqa_pkg::CNT_W-1:0]    fill_r;
  logic [fqa_pkg::CNT_W-1:0]    fill_nxt;
  logic [fqa_pkg::SUM_W-1:0]    sum_r;
  logic [fqa_pkg::SUM_W-1:0]    sum_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  fqa_pkg::out_item_t           out_r;
  fqa_pkg::out_item_t           out_nxt;
  logic                         neg_r;
  logic                         neg_nxt;

  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [fqa_pkg::VALUE_W-1:0]  ram_rd_data;
  logic                         div_start;
  logic                         div_done;
  fqa_pkg::div_req_t            div_req;
  logic [fqa_pkg::DIVD_W-1:0]   div_quo;
  logic [fqa_pkg::DIVD_W-1:0]   avg_full;
  logic [fqa_pkg::SUM_W-1:0]    sum_mag;

  fqa_ram #(
    .WIDTH(fqa_pkg::VALUE_W),
    .DEPTH(fqa_pkg::DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (cmd.value),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  fqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sum_mag          = sum_r[fqa_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_req.dividend = {sum_mag, {fqa_pkg::FRAC_W{1'b0}}};
  assign div_req.divisor  = fill_r;
  assign avg_full         = neg_r ? (~div_quo + 1'b1) : div_quo;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    neg_nxt       = neg_r;
    cmd_take      = 1'b0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_take) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_take          = 1'b1;
          out_nxt           = '0;
          out_nxt.status    = fqa_pkg::STAT_OK;
          out_nxt.occupancy = fqa_pkg::to_occ(fill_r);
          unique case (cmd.op)
            fqa_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (fill_r == fqa_pkg::FILL_MAX) begin
                out_nxt.status = fqa_pkg::STAT_FULL;
              end else begin
                ram_wr_en         = 1'b1;
                tail_nxt          = (tail_r == fqa_pkg::PTR_LAST) ? '0 : tail_r + 1'b1;
                fill_nxt          = fill_r + 1'b1;
                sum_nxt           = sum_r + fqa_pkg::ext_value(cmd.value);
                out_nxt.occupancy = fqa_pkg::to_occ(fill_r + 1'b1);
              end
            end
            fqa_pkg::OP_POP: begin
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = fqa_pkg::STAT_EMPTY;
                out_nxt.popped = fqa_pkg::POPPED_EMPTY;
              end else begin
                ram_rd_en = 1'b1;
                head_nxt  = (head_r == fqa_pkg::PTR_LAST) ? '0 : head_r + 1'b1;
                fill_nxt  = fill_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            fqa_pkg::OP_AVG: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                div_start = 1'b1;
                neg_nxt   = sum_r[fqa_pkg::SUM_W-1];
                state_nxt = S_DIV;
              end
            end
            fqa_pkg::OP_NOP: begin
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        sum_nxt           = sum_r - fqa_pkg::ext_value(ram_rd_data);
        out_nxt           = '0;
        out_nxt.status    = fqa_pkg::STAT_OK;
        out_nxt.popped    = ram_rd_data;
        out_nxt.occupancy = fqa_pkg::to_occ(fill_r);
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          out_nxt           = '0;
          out_nxt.status    = fqa_pkg::STAT_OK;
          out_nxt.average   = avg_full[fqa_pkg::AVG_W-1:0];
          out_nxt.occupancy = fqa_pkg::to_occ(fill_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
    neg_r <= neg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= fqa_pkg::FILL_MAX)
    else $error("Fill count exceeds the queue depth.");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("Empty queue with head and tail apart.");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("A result is pending while a transaction is still in progress.");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("Divider finished outside an average query.");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the FIFO queue with average, with a directed table and random traffic.
module tb;
  import fqa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = OP_NOP;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ROWS         = 26;

  typedef enum int {FILL_UP, DRAIN_DOWN, BALANCED} traffic_e;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } request_t;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] value;
    int                        reps;
    bit                        fixed;
    out_item_t                 want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  request_t  req_backlog[$];
  out_item_t awaited_results[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 24;
  int        recv_idle_pct = 68;
  int        est_fill = 0;
  traffic_e  traffic = BALANCED;

  logic signed [VALUE_W-1:0] model_mem [DEPTH];
  int                        model_head = 0;
  int                        model_tail = 0;
  int                        model_fill = 0;
  longint                    model_sum = 0;

  fifo_queue_with_average_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t fifo_mean_response(input in_item_t r);
    out_item_t res;
    longint    mag;
    res = '{STAT_OK, 32'sd0, 40'sd0, 6'd0};
    case (r.req_type)
      REQ_PUSH: begin
        if (model_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          model_mem[model_tail] = r.value;
          model_tail = (model_tail + 1) % DEPTH;
          model_fill++;
          model_sum += r.value;
        end
      end
      REQ_POP: begin
        if (model_fill == 0) begin
          res.status = STAT_EMPTY;
          res.popped = POPPED_EMPTY;
        end else begin
          res.popped = model_mem[model_head];
          model_head = (model_head + 1) % DEPTH;
          model_fill--;
          model_sum -= res.popped;
        end
      end
      REQ_AVG: begin
        if (model_fill != 0) begin
          mag = (model_sum < 0) ? -model_sum : model_sum;
          mag = (mag << FRAC_W) / model_fill;
          res.average = AVG_W'((model_sum < 0) ? -mag : mag);
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(model_fill);
    return res;
  endfunction

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.popped !== want.popped) begin
      $error("popped: expected %0d, got %0d", want.popped, got.popped);
      mismatches++;
    end
    if (got.average !== want.average) begin
      $error("average: expected %0d, got %0d", want.average, got.average);
      mismatches++;
    end
    if (got.occupancy !== want.occupancy) begin
      $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
      mismatches++;
    end
  endtask

  task automatic enqueue(input logic [REQ_W-1:0] req, input logic signed [VALUE_W-1:0] v,
                         input bit fixed, input out_item_t want);
    request_t t;
    t.item.req_type = req;
    t.item.value = v;
    t.fixed = fixed;
    t.want = want;
    req_backlog.push_back(t);
    if (req == REQ_PUSH && est_fill < DEPTH) begin
      est_fill++;
    end else if (req == REQ_POP && est_fill > 0) begin
      est_fill--;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 32'sd0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2: v = $signed($urandom_range(2000)) - 32'sd1000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic gen_traffic(input int count);
    int               push_pct;
    int               r;
    logic [REQ_W-1:0] req;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(39) == 0) begin
        traffic = traffic_e'($urandom_range(2));
      end
      if (est_fill == DEPTH && traffic == FILL_UP && $urandom_range(3) == 0) begin
        traffic = DRAIN_DOWN;
      end else if (est_fill == 0 && traffic == DRAIN_DOWN && $urandom_range(3) == 0) begin
        traffic = FILL_UP;
      end
      push_pct = (traffic == FILL_UP) ? 75 : (traffic == DRAIN_DOWN) ? 25 : 50;
      r = $urandom_range(99);
      if (r < 12) begin
        req = REQ_AVG;
      end else if (r < 15) begin
        req = REQ_SPARE;
      end else if ($urandom_range(99) < push_pct) begin
        req = REQ_PUSH;
      end else begin
        req = REQ_POP;
      end
      enqueue(req, pick_value(), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int send_idle, input int recv_idle, input int count);
    @(negedge clk);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    gen_traffic(count);
    while (req_backlog.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    request_t  accepted;
    out_item_t predicted;
    if (rst_n) begin
      if (push && !full) begin
        accepted = req_backlog.pop_front();
        predicted = fifo_mean_response(accepted.item);
        awaited_results.push_back(accepted.fixed ? accepted.want : predicted);
      end
      if (!(push && full)) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_data <= req_backlog[0].item;
        end else begin
          push <= 1'b0;
        end
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d, occupancy %0d",
                 out_data.status, out_data.occupancy);
          mismatches++;
        end else begin
          compare_result(out_data, awaited_results.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [ROWS];
    directed_rows = '{
      '{REQ_POP,   32'sd0,         1,  1'b1, '{STAT_EMPTY, POPPED_EMPTY, 40'sd0, 6'd0}},
      '{REQ_AVG,   32'sd0,         1,  1'b1, '{STAT_OK, 32'sd0, 40'sd0, 6'd0}},
      '{REQ_SPARE, 32'shDEADBEEF,  1,  1'b1, '{STAT_OK, 32'sd0, 40'sd0, 6'd0}},
      '{REQ_PUSH,  VAL_MAX,        1,  1'b1, '{STAT_OK, 32'sd0, 40'sd0, 6'd1}},
      '{REQ_PUSH,  VAL_MIN,        1,  1'b1, '{STAT_OK, 32'sd0, 40'sd0, 6'd2}},
      '{REQ_AVG,   32'sd0,         1,  1'b1, '{STAT_OK, 32'sd0, -40'sd128, 6'd2}},
      '{REQ_POP,   32'sd0,         1,  1'b1, '{STAT_OK, VAL_MAX, 40'sd0, 6'd1}},
      '{REQ_POP,   32'sd0,         1,  1'b1, '{STAT_OK, VAL_MIN, 40'sd0, 6'd0}},
      '{REQ_POP,   32'sd0,         1,  1'b1, '{STAT_EMPTY, POPPED_EMPTY, 40'sd0, 6'd0}},
      '{REQ_PUSH,  VAL_MAX,        32, 1'b0, '0},
      '{REQ_AVG,   32'sd0,         1,  1'b1, '{STAT_OK, 32'sd0, 40'sh7F_FFFF_FF00, 6'd32}},
      '{REQ_PUSH,  32'sd5,         1,  1'b1, '{STAT_FULL, 32'sd0, 40'sd0, 6'd32}},
      '{REQ_POP,   32'sd0,         32, 1'b0, '0},
      '{REQ_PUSH,  VAL_MIN,        32, 1'b0, '0},
      '{REQ_AVG,   32'sd0,         1,  1'b1, '{STAT_OK, 32'sd0, 40'sh80_0000_0000, 6'd32}},
      '{REQ_PUSH,  -32'sd1,        1,  1'b1, '{STAT_FULL, 32'sd0, 40'sd0, 6'd32}},
      '{REQ_POP,   32'sd0,         31, 1'b0, '0},
      '{REQ_AVG,   32'sd0,         1,  1'b0, '0},
      '{REQ_POP,   32'sd0,         1,  1'b0, '0},
      '{REQ_PUSH,  32'sd1,         1,  1'b0, '0},
      '{REQ_PUSH,  32'sd0,         2,  1'b0, '0},
      '{REQ_AVG,   32'sd0,         1,  1'b0, '0},
      '{REQ_PUSH,  -32'sd2,        1,  1'b0, '0},
      '{REQ_PUSH,  32'sd0,         1,  1'b0, '0},
      '{REQ_AVG,   32'sd0,         1,  1'b0, '0},
      '{REQ_SPARE, 32'sh1234_5678, 1,  1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        enqueue(directed_rows[i].req, directed_rows[i].value, directed_rows[i].fixed,
                directed_rows[i].want);
      end
    end
    run_phase(24, 68, 470);
    run_phase(68, 24, 465);
    run_phase(0, 0, 465);
    while (awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fqa_pkg.sv
rtl/fqa_ram.sv
rtl/fqa_div.sv
rtl/fqa_front.sv
rtl/fqa_back.sv
rtl/fifo_queue_with_average_top.sv
tb/sv/tb.sv
